FILE: rtl/core/rmps_pkg.sv
// Shared types, constants and fixed-point helpers for the ray march pixel shader.
`timescale 1ns / 1ps
package rmps_pkg;

  localparam int DefScreenCols = 80;
  localparam int DefScreenRows = 23;
  localparam int DefMaxSteps   = 64;

  localparam logic signed [31:0] OneQ      = 32'sd1048576;
  localparam logic signed [31:0] Step0Q    = 32'sd104858;
  localparam logic signed [31:0] FarQ      = 32'sd8388608;
  localparam logic signed [31:0] HitEps    = 32'sd1;
  localparam logic signed [31:0] ShadowEps = 32'sd105;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgSphereX  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSphereY  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgSphereZ  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgSphereR  = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgFloorH   = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgLightX   = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgLightY   = 8'd6;
  localparam logic [CfgIdxW-1:0] CfgLightZ   = 8'd7;

  localparam logic [2:0] ShadeSphere = 3'd0;
  localparam logic [2:0] ShadeFloor  = 3'd2;
  localparam logic [2:0] ShadeBack   = 3'd5;

  typedef struct packed {
    logic [6:0] column;
    logic [4:0] row;
  } in_t;

  typedef struct packed {
    logic [2:0] shade;
    logic [7:0] glyph;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q.20 product scaling: truncate toward zero, then saturate.
  function automatic logic signed [31:0] mulq(input logic signed [63:0] prod);
    logic signed [63:0] t;
    t = prod + (prod[63] ? 64'sd1048575 : 64'sd0);
    return sat32(t >>> 20);
  endfunction

  function automatic logic [7:0] glyph_of(input logic [2:0] shade);
    logic [7:0] g;
    case (shade)
      3'd0:    g = 8'h40;
      3'd1:    g = 8'h2b;
      3'd2:    g = 8'h3a;
      3'd3:    g = 8'h2d;
      3'd4:    g = 8'h2e;
      default: g = 8'h20;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/ray_march_pixel_shader.sv
// Top level: sequencer and registers of the sphere-tracing pixel shader.
//
// Usage: a pixel (column, row) is offered on the in_* valid/ready channel;
// the shade and its glyph come back as one transaction on out_* valid/ready.
// Scene registers are written on the cfg_* channel (index, data), always
// ready; the user must write them only while no pixel is in flight, as the
// block itself does not enforce this. One pixel is worked at a time;
// in_ready_o is high only while idle. Two divisions set up the view ray,
// normalizing takes a length and three divisions, and each march step
// takes one length (two in the shadow march, where the light distance is
// measured too). The run time is set by the shared multiplier, the
// bit-serial divider and the square root unit.
// Reset returns all scene registers to their defaults and empties the
// output register. A stalled receiver holds the result in the output
// register; the next pixel is still accepted, and its result waits until
// the earlier transaction completes.
`timescale 1ns / 1ps
module ray_march_pixel_shader #(
  parameter int SCREEN_COLS = rmps_pkg::DefScreenCols,
  parameter int SCREEN_ROWS = rmps_pkg::DefScreenRows,
  parameter int MAX_STEPS   = rmps_pkg::DefMaxSteps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rmps_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rmps_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rmps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmps_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int IterW   = $clog2(MAX_STEPS + 1);
  localparam int AspK    = (SCREEN_COLS / SCREEN_ROWS) * 8;
  localparam int UxDen   = 13 * SCREEN_COLS;

  typedef enum logic [12:0] {
    StIdle    = 13'b0000000000001,
    StDivGo   = 13'b0000000000010,
    StDivWait = 13'b0000000000100,
    StLsq     = 13'b0000000001000,
    StLacc    = 13'b0000000010000,
    StLsqrt   = 13'b0000000100000,
    StPmul    = 13'b0000001000000,
    StPacc    = 13'b0000010000000,
    StPdone   = 13'b0000100000000,
    StMchk    = 13'b0001000000000,
    StEval    = 13'b0010000000000,
    StQeval   = 13'b0100000000000,
    StDone    = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    DivUx  = 2'd0,
    DivUy  = 2'd1,
    DivNrm = 2'd2
  } div_tgt_e;

  typedef enum logic [1:0] {
    CtxNorm   = 2'd0,
    CtxSphere = 2'd1,
    CtxLight  = 2'd2
  } ctx_e;

  state_e   state_q;
  div_tgt_e tgt_q;
  ctx_e     ctx_q;
  logic     shadow_q;
  logic [1:0] k_q;
  logic [IterW-1:0] iter_q;

  logic [23:0] sph_x_q, sph_y_q, sph_z_q, floor_q, lgt_x_q, lgt_y_q, lgt_z_q;
  logic [22:0] radius_q;

  logic [6:0] col_q;
  logic [4:0] row_q;
  logic signed [31:0] dir_q  [3];
  logic signed [31:0] base_q [3];
  logic signed [31:0] p_q    [3];
  logic signed [31:0] diff_q [3];
  logic signed [31:0] step_q, len_q, ds_q, dg_q;
  logic [63:0] acc_q;
  logic [2:0]  shade_q;
  logic        out_valid_q;
  rmps_pkg::out_t out_q;

  logic signed [31:0] center [3];
  logic signed [31:0] light  [3];
  logic signed [31:0] radius_s, floor_s;

  assign center[0] = {{8{sph_x_q[23]}}, sph_x_q};
  assign center[1] = {{8{sph_y_q[23]}}, sph_y_q};
  assign center[2] = {{8{sph_z_q[23]}}, sph_z_q};
  assign light[0]  = {{8{lgt_x_q[23]}}, lgt_x_q};
  assign light[1]  = {{8{lgt_y_q[23]}}, lgt_y_q};
  assign light[2]  = {{8{lgt_z_q[23]}}, lgt_z_q};
  assign radius_s  = {9'd0, radius_q};
  assign floor_s   = {{8{floor_q[23]}}, floor_q};

  // Shared units.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done, sqrt_start, sqrt_done;
  logic signed [63:0] div_num, div_q;
  logic        [31:0] div_den, root;

  rmps_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  rmps_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  rmps_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .val_i(acc_q + prod),
    .done_o(sqrt_done), .root_o(root)
  );

  // View ray numerators from the pixel position.
  logic signed [12:0] col_term, row_term;
  logic signed [26:0] ux_prod;
  assign col_term = $signed({5'd0, col_q, 1'b0}) - 13'(SCREEN_COLS);
  assign row_term = 13'(SCREEN_ROWS) - $signed({7'd0, row_q, 1'b0});
  assign ux_prod  = 27'(col_term) * 27'(AspK);

  always_comb begin
    mul_a = diff_q[k_q];
    mul_b = diff_q[k_q];
    if (state_q == StPmul) begin
      mul_a = dir_q[k_q];
      mul_b = step_q;
    end
  end

  always_comb begin
    unique case (tgt_q)
      DivUx: begin
        div_num = 64'(ux_prod) <<< 20;
        div_den = 32'(UxDen);
      end
      DivUy: begin
        div_num = 64'(row_term) <<< 20;
        div_den = 32'(SCREEN_ROWS);
      end
      default: begin
        div_num = 64'(diff_q[k_q]) <<< 20;
        div_den = len_q;
      end
    endcase
  end

  assign div_start  = state_q == StDivGo;
  assign sqrt_start = (state_q == StLacc) && (k_q == 2'd2);

  logic signed [31:0] len_sat, dmin;
  assign len_sat = root[31] ? 32'sh7fffffff : $signed(root);
  assign dmin    = (ds_q < dg_q) ? ds_q : dg_q;

  // Scene registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sph_x_q  <= 24'd0;
      sph_y_q  <= 24'd0;
      sph_z_q  <= 24'd3145728;
      radius_q <= 23'd1048576;
      floor_q  <= 24'hf00000;
      lgt_x_q  <= 24'd2097152;
      lgt_y_q  <= 24'd2097152;
      lgt_z_q  <= 24'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rmps_pkg::CfgSphereX: sph_x_q  <= cfg_data_i[23:0];
        rmps_pkg::CfgSphereY: sph_y_q  <= cfg_data_i[23:0];
        rmps_pkg::CfgSphereZ: sph_z_q  <= cfg_data_i[23:0];
        rmps_pkg::CfgSphereR: radius_q <= cfg_data_i[22:0];
        rmps_pkg::CfgFloorH:  floor_q  <= cfg_data_i[23:0];
        rmps_pkg::CfgLightX:  lgt_x_q  <= cfg_data_i[23:0];
        rmps_pkg::CfgLightY:  lgt_y_q  <= cfg_data_i[23:0];
        rmps_pkg::CfgLightZ:  lgt_z_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle:    if (in_valid_i) state_q <= StDivGo;
        StDivGo:   state_q <= StDivWait;
        StDivWait: begin
          if (div_done) begin
            if (tgt_q == DivUy) begin
              state_q <= StLsq;
            end else if (tgt_q == DivNrm && k_q == 2'd2) begin
              state_q <= StMchk;
            end else begin
              state_q <= StDivGo;
            end
          end
        end
        StLsq:  state_q <= StLacc;
        StLacc: state_q <= (k_q == 2'd2) ? StLsqrt : StLsq;
        StLsqrt: begin
          if (sqrt_done) begin
            unique case (ctx_q)
              CtxNorm:   state_q <= (len_sat == 32'sd0) ? StMchk : StDivGo;
              CtxSphere: state_q <= shadow_q ? StQeval : StEval;
              default: begin
                state_q <= (len_sat > rmps_pkg::OneQ && step_q < rmps_pkg::FarQ) ?
                           StLsq : StDone;
              end
            endcase
          end
        end
        StMchk: begin
          state_q <= (iter_q >= IterW'(MAX_STEPS) || step_q >= rmps_pkg::FarQ) ?
                     StDone : StPmul;
        end
        StPmul:  state_q <= StPacc;
        StPacc:  state_q <= (k_q == 2'd2) ? StPdone : StPmul;
        StPdone: state_q <= StLsq;
        StEval:  state_q <= (dmin < rmps_pkg::HitEps) ? StLsq : StMchk;
        StQeval: state_q <= (dmin < rmps_pkg::ShadowEps) ? StDone : StMchk;
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        col_q    <= in_data_i.column;
        row_q    <= in_data_i.row;
        tgt_q    <= DivUx;
        shadow_q <= 1'b0;
        shade_q  <= rmps_pkg::ShadeBack;
        for (int i = 0; i < 3; i++) base_q[i] <= 32'sd0;
      end
      StDivWait: begin
        if (div_done) begin
          unique case (tgt_q)
            DivUx: begin
              diff_q[0] <= rmps_pkg::sat32(div_q);
              tgt_q     <= DivUy;
            end
            DivUy: begin
              diff_q[1] <= rmps_pkg::sat32(div_q);
              diff_q[2] <= rmps_pkg::OneQ;
              ctx_q     <= CtxNorm;
              k_q       <= 2'd0;
              acc_q     <= '0;
            end
            default: begin
              dir_q[k_q] <= rmps_pkg::sat32(div_q);
              k_q        <= k_q + 2'd1;
              step_q     <= rmps_pkg::Step0Q;
              iter_q     <= '0;
            end
          endcase
        end
      end
      StLacc: begin
        acc_q <= acc_q + prod;
        if (k_q != 2'd2) k_q <= k_q + 2'd1;
      end
      StLsqrt: begin
        if (sqrt_done) begin
          len_q <= len_sat;
          k_q   <= 2'd0;
          acc_q <= '0;
          unique case (ctx_q)
            CtxNorm: begin
              tgt_q  <= DivNrm;
              step_q <= rmps_pkg::Step0Q;
              iter_q <= '0;
              if (len_sat == 32'sd0) begin
                for (int i = 0; i < 3; i++) dir_q[i] <= 32'sd0;
              end
            end
            CtxSphere: begin
              ds_q <= rmps_pkg::sat32(64'(len_sat) - 64'(radius_s));
              dg_q <= rmps_pkg::sat32(64'(p_q[1]) - 64'(floor_s));
            end
            default: begin
              ctx_q <= CtxSphere;
              for (int i = 0; i < 3; i++) begin
                diff_q[i] <= rmps_pkg::sat32(64'(p_q[i]) - 64'(center[i]));
              end
            end
          endcase
        end
      end
      StMchk: k_q <= 2'd0;
      StPacc: begin
        p_q[k_q] <= rmps_pkg::sat32(64'(base_q[k_q]) + 64'(rmps_pkg::mulq(prod)));
        if (k_q != 2'd2) k_q <= k_q + 2'd1;
      end
      StPdone: begin
        k_q   <= 2'd0;
        acc_q <= '0;
        ctx_q <= shadow_q ? CtxLight : CtxSphere;
        for (int i = 0; i < 3; i++) begin
          diff_q[i] <= shadow_q ? rmps_pkg::sat32(64'(light[i]) - 64'(p_q[i]))
                                : rmps_pkg::sat32(64'(p_q[i]) - 64'(center[i]));
        end
      end
      StEval: begin
        if (dmin < rmps_pkg::HitEps) begin
          shade_q  <= (ds_q < dg_q) ? rmps_pkg::ShadeSphere : rmps_pkg::ShadeFloor;
          shadow_q <= 1'b1;
          ctx_q    <= CtxNorm;
          k_q      <= 2'd0;
          acc_q    <= '0;
          for (int i = 0; i < 3; i++) begin
            base_q[i] <= p_q[i];
            diff_q[i] <= rmps_pkg::sat32(64'(light[i]) - 64'(p_q[i]));
          end
        end else begin
          step_q <= rmps_pkg::sat32(64'(step_q) + 64'(dmin));
          iter_q <= iter_q + IterW'(1);
        end
      end
      StQeval: begin
        if (dmin < rmps_pkg::ShadowEps) begin
          shade_q <= shade_q + 3'd1;
        end else begin
          step_q <= rmps_pkg::sat32(64'(step_q) + 64'(dmin));
          iter_q <= iter_q + IterW'(1);
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.shade <= shade_q;
          out_q.glyph <= rmps_pkg::glyph_of(shade_q);
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: rtl/core/rmps_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
`timescale 1ns / 1ps
module rmps_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/core/rmps_div.sv
// Iterative restoring divider: signed 64-bit dividend by positive 32-bit divisor.
`timescale 1ns / 1ps
module rmps_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic        [31:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic [63:0] dvd_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q[31:0], dvd_q[63]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63];
      dvd_q <= num_i[63] ? -num_i : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
      dvd_q <= {dvd_q[62:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

FILE: rtl/core/rmps_sqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
`timescale 1ns / 1ps
module rmps_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic [63:0] rb;

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

FILE: rtl/core/rmps_checker.sv
// Port-level checks of the ray march pixel shader, bound to the top level.
`timescale 1ns / 1ps
module rmps_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rmps_pkg::out_t out_data_o
);

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // After a pixel is taken, the block is not ready again in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("pixel accepted in back-to-back cycles");

  a_shade_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.shade == 3'd0 || out_data_o.shade == 3'd1 ||
                     out_data_o.shade == 3'd2 || out_data_o.shade == 3'd3 ||
                     out_data_o.shade == 3'd5))
    else $error("illegal shade code");

  a_glyph_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.glyph == rmps_pkg::glyph_of(out_data_o.shade))
    else $error("glyph does not match shade");

endmodule

bind ray_march_pixel_shader rmps_checker u_rmps_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

FILE: tb/ray_march_pixel_shader_tb.sv
// Self-checking testbench for the ray march pixel shader, with a scoreboard that predicts shades.
`timescale 1ns / 1ps
module ray_march_pixel_shader_tb;
  import rmps_pkg::*;

  localparam int Cols       = DefScreenCols;
  localparam int Rows       = DefScreenRows;
  localparam int MaxSteps   = DefMaxSteps;
  localparam int RandPixels = 950;
  localparam int RandScenes = 8;
  localparam longint CycleLimit = 40_000_000;

  typedef struct {
    int x;
    int y;
    int z;
  } vec_t;

  class shade_board;
    int    scene [8];
    out_t  pending_shades[$];
    int    errors;
    int    checked;
    int    shade_hist [8];
    byte   glyphs [6] = '{8'h40, 8'h2b, 8'h3a, 8'h2d, 8'h2e, 8'h20};

    function new();
      scene = '{0, 0, 3145728, 1048576, -1048576, 2097152, 2097152, 0};
      errors = 0;
      checked = 0;
      foreach (shade_hist[i]) shade_hist[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgSphereR) begin
        scene[idx] = int'({9'd0, data[22:0]});
      end else if (idx <= CfgLightZ) begin
        scene[idx] = int'({{8{data[23]}}, data[23:0]});
      end
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int qmul(int a, int b);
      return sat((longint'(a) * longint'(b)) / 1048576);
    endfunction

    function int span(vec_t a, vec_t b);
      longint dx, dy, dz;
      longint unsigned v, r, bitv;
      dx = sat(longint'(a.x) - b.x);
      dy = sat(longint'(a.y) - b.y);
      dz = sat(longint'(a.z) - b.z);
      v = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
      r = 0;
      bitv = 64'h4000000000000000;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      if (r[31:0] > 32'h7fffffff) return 32'h7fffffff;
      return int'(r[31:0]);
    endfunction

    function vec_t unit(vec_t v);
      vec_t z;
      int len;
      z = '{0, 0, 0};
      len = span(v, z);
      if (len == 0) return z;
      z.x = sat((longint'(v.x) * 1048576) / len);
      z.y = sat((longint'(v.y) * 1048576) / len);
      z.z = sat((longint'(v.z) * 1048576) / len);
      return z;
    endfunction

    function vec_t along(vec_t base, vec_t dir, int t);
      vec_t p;
      p.x = sat(longint'(base.x) + qmul(dir.x, t));
      p.y = sat(longint'(base.y) + qmul(dir.y, t));
      p.z = sat(longint'(base.z) + qmul(dir.z, t));
      return p;
    endfunction

    function int ball_gap(vec_t p);
      vec_t c;
      c = '{scene[0], scene[1], scene[2]};
      return sat(longint'(span(p, c)) - scene[3]);
    endfunction

    function int floor_gap(vec_t p);
      return sat(longint'(p.y) - scene[4]);
    endfunction

    // Traces one pixel; also returns where the primary ray struck, if it did.
    function out_t shade_pixel(in_t px, output vec_t hit_pt, output bit struck);
      longint col, row, aspect;
      vec_t ray, dir, lamp, q, org;
      int stp, ds, dg, d;
      bit blocked;
      logic [2:0] shade;
      out_t res;
      col = px.column;
      row = px.row;
      aspect = Cols / Rows;
      org = '{0, 0, 0};
      lamp = '{scene[5], scene[6], scene[7]};
      shade = ShadeBack;
      struck = 0;
      hit_pt = org;
      ray.x = sat(((2 * col - Cols) * aspect * 8 * 1048576) / (13 * longint'(Cols)));
      ray.y = sat(((longint'(Rows) - 2 * row) * 1048576) / Rows);
      ray.z = OneQ;
      dir = unit(ray);
      stp = Step0Q;
      for (int it = 0; it < MaxSteps && stp < FarQ; it++) begin
        q = along(org, dir, stp);
        ds = ball_gap(q);
        dg = floor_gap(q);
        d = ds < dg ? ds : dg;
        if (d < HitEps) begin
          shade = ds < dg ? ShadeSphere : ShadeFloor;
          struck = 1;
          hit_pt = q;
          blocked = 0;
          dir = unit('{sat(longint'(lamp.x) - q.x), sat(longint'(lamp.y) - q.y),
                       sat(longint'(lamp.z) - q.z)});
          stp = Step0Q;
          for (int k = 0; k < MaxSteps; k++) begin
            q = along(hit_pt, dir, stp);
            if (!(span(lamp, q) > OneQ && stp < FarQ)) break;
            ds = ball_gap(q);
            dg = floor_gap(q);
            d = ds < dg ? ds : dg;
            if (d < ShadowEps) begin
              blocked = 1;
              break;
            end
            stp = sat(longint'(stp) + d);
          end
          if (blocked) shade = shade + 3'd1;
          break;
        end
        stp = sat(longint'(stp) + d);
      end
      res.shade = shade;
      res.glyph = glyphs[shade];
      return res;
    endfunction

    function void note_pixel(in_t px);
      vec_t h;
      bit s;
      pending_shades.push_back(shade_pixel(px, h, s));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_shades.size() == 0) begin
        $display("%0t: unexpected result shade=%0d glyph=%h", $time, got.shade, got.glyph);
        errors++;
        return;
      end
      want = pending_shades.pop_front();
      checked++;
      shade_hist[got.shade]++;
      if (got.shade !== want.shade) begin
        $display("%0t: shade mismatch, expected %0d, actual %0d", $time, want.shade, got.shade);
        errors++;
      end
      if (got.glyph !== want.glyph) begin
        $display("%0t: glyph mismatch, expected %h, actual %h", $time, want.glyph, got.glyph);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  shade_board board = new();
  int send_idle = 0;
  int recv_stall = 0;
  int pixels_sent = 0;
  int scenes_set = 0;
  longint cycles = 0;

  ray_march_pixel_shader i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Handshake values are stable at the falling edge, ahead of the accepting edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_pixel(in_t px);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(negedge clk_i); while (!in_ready_o);
    board.note_pixel(px);
    pixels_sent++;
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_shades.size() != 0);
  endtask

  // Writes every scene register, plus one write to an index the block ignores.
  task automatic load_scene(int vals [8]);
    for (int i = 0; i < 8; i++) begin
      write_reg(CfgIdxW'(i), {8'($urandom()), vals[i][23:0]});
    end
    write_reg(CfgIdxW'($urandom_range(8, 255)), $urandom());
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    scenes_set++;
  endtask

  function automatic int qrand(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic random_pixels(int n);
    in_t px;
    for (int i = 0; i < n; i++) begin
      if (pixels_sent < 330) begin
        send_idle = 36;
        recv_stall = 55;
      end else if (pixels_sent < 660) begin
        send_idle = 55;
        recv_stall = 36;
      end else begin
        send_idle = 0;
        recv_stall = 0;
      end
      if ($urandom_range(0, 99) < 85) begin
        px.column = 7'($urandom_range(0, Cols - 1));
        px.row    = 5'($urandom_range(0, Rows - 1));
      end else begin
        px.column = 7'($urandom());
        px.row    = 5'($urandom());
      end
      send_pixel(px);
    end
  endtask

  initial begin
    int vals [8];
    in_t px;
    vec_t hp;
    bit struck;
    out_t dummy;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default scene: corners, center, screen edges and off-screen indices.
    send_pixel('{7'd0, 5'd0});
    send_pixel('{7'd79, 5'd22});
    send_pixel('{7'd0, 5'd22});
    send_pixel('{7'd79, 5'd0});
    send_pixel('{7'd40, 5'd11});
    send_pixel('{7'd40, 5'd20});
    send_pixel('{7'd30, 5'd18});
    send_pixel('{7'd50, 5'd8});
    send_pixel('{7'd127, 5'd31});
    send_pixel('{7'd80, 5'd23});
    send_pixel('{7'd127, 5'd0});
    send_pixel('{7'd0, 5'd31});
    drain();

    // Light placed exactly on a floor hit point, so the shadow ray has no direction.
    px = '{7'd40, 5'd20};
    dummy = board.shade_pixel(px, hp, struck);
    vals = board.scene;
    if (struck) begin
      vals[5] = hp.x;
      vals[6] = hp.y;
      vals[7] = hp.z;
    end
    load_scene(vals);
    send_pixel(px);
    send_pixel('{7'd41, 5'd20});
    drain();

    // Register extremes: most negative positions with zero radius, then the reverse.
    vals = '{default: 32'hff800000};
    vals[3] = 0;
    load_scene(vals);
    send_pixel('{7'd40, 5'd11});
    send_pixel('{7'd0, 5'd22});
    send_pixel('{7'd79, 5'd0});
    drain();
    vals = '{default: 32'h007fffff};
    load_scene(vals);
    send_pixel('{7'd40, 5'd11});
    send_pixel('{7'd79, 5'd22});
    send_pixel('{7'd10, 5'd3});
    drain();

    for (int s = 0; s < RandScenes; s++) begin
      vals[0] = qrand(-2097152, 2097152);
      vals[1] = qrand(-1572864, 1572864);
      vals[2] = qrand(1572864, 6291456);
      vals[3] = qrand(209715, 2097152);
      vals[4] = qrand(-3145728, 0);
      vals[5] = qrand(-4194304, 4194304);
      vals[6] = qrand(0, 5242880);
      vals[7] = qrand(-2097152, 4194304);
      if (s == RandScenes - 1) vals[3] = 0;
      load_scene(vals);
      random_pixels(RandPixels / RandScenes);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("Shaded %0d pixels over %0d scene loads plus the reset scene.",
             board.checked, scenes_set);
    $display("Shade counts: sphere %0d/%0d, floor %0d/%0d, background %0d.",
             board.shade_hist[0], board.shade_hist[1], board.shade_hist[2],
             board.shade_hist[3], board.shade_hist[5]);
    if (board.errors == 0 && board.pending_shades.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rmps_pkg.sv
rtl/core/rmps_mul.sv
rtl/core/rmps_div.sv
rtl/core/rmps_sqrt.sv
rtl/core/ray_march_pixel_shader.sv
rtl/core/rmps_checker.sv
tb/ray_march_pixel_shader_tb.sv
